### design/ght_pkg.sv
// Package for the generational handle table: sizes, codes, beat and record types.
// No dependencies; imported by ght_update and generational_handle_table.
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;

  localparam int SLOTS    = 1024;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int DEPTH_W  = $clog2(SLOTS + 1);
  localparam int GEN_W    = 32;
  localparam int REFS_W   = 16;
  localparam int SIZE_W   = 32;
  localparam int BYTES_W  = 48;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_LOOKUP  = 3'd1,
    OP_RETAIN  = 3'd2,
    OP_RELEASE = 3'd3,
    OP_UNTRACK = 3'd4
  } ght_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2,
    ST_BAD  = 2'd3
  } ght_status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ght_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] byte_size;
    logic [IDX_W-1:0]  slot_index;
    logic [GEN_W-1:0]  handle_generation;
  } ght_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    out_index;
    logic [GEN_W-1:0]    out_generation;
    logic [REFS_W-1:0]   refs_after;
    logic                released;
    logic [DEPTH_W-1:0]  live_objects;
    logic [BYTES_W-1:0]  total_bytes;
    logic [BYTES_W-1:0]  peak_bytes;
  } ght_out_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic              live;
    logic [REFS_W-1:0] refs;
    logic [SIZE_W-1:0] size;
  } ght_rec_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] free_depth;
    logic [GEN_W-1:0]   gen;
    logic [DEPTH_W-1:0] live;
    logic [BYTES_W-1:0] bytes;
    logic [BYTES_W-1:0] peak;
  } ght_ctr_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    ght_rec_t         data;
  } ght_rec_wr_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } ght_stk_wr_t;

endpackage
`default_nettype wire

### design/ght_update.sv
// Operation datapath: from the fetched slot record, stack top and counters,
// forms the result beat, memory write-backs and next counters. Uses ght_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ght_update import ght_pkg::*; (
  input  ght_in_t      req,
  input  ght_rec_t     rec,
  input  logic         rec_valid,
  input  logic [IDX_W-1:0] stack_top,
  input  ght_ctr_t     ctr,
  output ght_ctr_t     ctr_nxt,
  output ght_out_t     res,
  output ght_rec_wr_t  rec_wr,
  output ght_stk_wr_t  stk_wr
);

  logic [GEN_W-1:0]   gen_seen;
  logic               live_seen;
  logic               handle_ok;
  logic               do_free;
  logic [REFS_W-1:0]  refs_dec;
  logic [GEN_W-1:0]   gen_inc;
  logic [BYTES_W-1:0] bytes_add;

  assign gen_seen  = rec_valid ? rec.gen : '0;
  assign live_seen = rec_valid && rec.live;
  assign handle_ok = live_seen && (req.handle_generation != '0)
                     && (gen_seen == req.handle_generation);
  assign refs_dec  = (rec.refs != '0) ? rec.refs - REFS_W'(1) : '0;
  assign gen_inc   = ctr.gen + GEN_W'(1);
  assign bytes_add = ctr.bytes + BYTES_W'(req.byte_size);

  always_comb begin
    ctr_nxt = ctr;
    res = '0;
    res.out_index = req.slot_index;
    rec_wr = '0;
    rec_wr.addr = req.slot_index;
    rec_wr.data = rec;
    stk_wr = '0;
    do_free = 1'b0;

    case (req.op)
      OP_ALLOC: begin
        res.out_index = '0;
        if (req.byte_size == '0) begin
          res.status = ST_ZERO;
        end else if (ctr.free_depth == '0) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_OK;
          res.out_index = stack_top;
          res.out_generation = ctr.gen;
          res.refs_after = REFS_W'(1);
          rec_wr.we = 1'b1;
          rec_wr.addr = stack_top;
          rec_wr.data.gen = ctr.gen;
          rec_wr.data.live = 1'b1;
          rec_wr.data.refs = REFS_W'(1);
          rec_wr.data.size = req.byte_size;
          ctr_nxt.free_depth = ctr.free_depth - DEPTH_W'(1);
          ctr_nxt.gen = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
          ctr_nxt.live = ctr.live + DEPTH_W'(1);
          ctr_nxt.bytes = bytes_add;
          if (bytes_add > ctr.peak) begin
            ctr_nxt.peak = bytes_add;
          end
        end
      end
      OP_LOOKUP, OP_RETAIN, OP_RELEASE, OP_UNTRACK: begin
        res.out_generation = gen_seen;
        if (!handle_ok) begin
          res.status = ST_BAD;
        end else begin
          res.status = ST_OK;
          case (req.op)
            OP_LOOKUP: begin
              res.refs_after = rec.refs;
            end
            OP_RETAIN: begin
              rec_wr.we = 1'b1;
              if (rec.refs != REFS_MAX) begin
                rec_wr.data.refs = rec.refs + REFS_W'(1);
              end
              res.refs_after = rec_wr.data.refs;
            end
            OP_RELEASE: begin
              rec_wr.we = 1'b1;
              rec_wr.data.refs = refs_dec;
              res.refs_after = refs_dec;
              do_free = (refs_dec == '0);
            end
            default: begin
              do_free = 1'b1;
            end
          endcase
        end
      end
      default: begin
        res.status = ST_BAD;
      end
    endcase

    if (do_free) begin
      res.released = 1'b1;
      res.refs_after = '0;
      rec_wr.we = 1'b1;
      rec_wr.data.live = 1'b0;
      rec_wr.data.refs = '0;
      if (ctr.free_depth < DEPTH_W'(SLOTS)) begin
        stk_wr.we = 1'b1;
        stk_wr.addr = ctr.free_depth[IDX_W-1:0];
        stk_wr.data = req.slot_index;
        ctr_nxt.free_depth = ctr.free_depth + DEPTH_W'(1);
      end
      if (ctr.live != '0) begin
        ctr_nxt.live = ctr.live - DEPTH_W'(1);
      end
      ctr_nxt.bytes = ctr.bytes - BYTES_W'(rec.size);
    end

    res.live_objects = ctr_nxt.live;
    res.total_bytes = ctr_nxt.bytes;
    res.peak_bytes = ctr_nxt.peak;
  end

endmodule
`default_nettype wire

### design/generational_handle_table.sv
// Top level of the generational handle table: handshakes, sequencer, slot and
// free-stack memories. Depends on ght_pkg and ght_update.
//
//   channel  dir  handshake             beat
//   in       in   in_valid / in_ready    ght_in_t  (op, size, index, generation)
//   out      out  out_valid / out_ready  ght_out_t (status, handle, counters)
//
// Each operation passes S_IDLE, where the beat is taken and the slot record and
// the stack top are read synchronously, then S_EXEC, which modifies and writes
// back. The result sits in an output register, so the next beat is taken while
// it waits. A stalled output holds the write-back until the register frees. The
// memories are not reset; unwritten parts are tracked by the lowest stack depth.
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_table import ght_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ght_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ght_out_t out_data
);

  ght_state_t state_r, state_nxt;

  ght_in_t            req_r;
  ght_ctr_t           ctr_r;
  ght_ctr_t           ctr_nxt;
  logic [DEPTH_W-1:0] min_depth_r;
  logic [IDX_W-1:0]   pos_r;
  logic               out_valid_r;
  ght_out_t           out_data_r;

  ght_rec_t           rec_mem [SLOTS];
  logic [IDX_W-1:0]   stk_mem [SLOTS];
  ght_rec_t           rec_q;
  logic [IDX_W-1:0]   stk_q;

  logic               accept;
  logic               commit;
  logic               rec_valid;
  logic [IDX_W-1:0]   stack_top;
  ght_out_t           res;
  ght_rec_wr_t        rec_wr;
  ght_stk_wr_t        stk_wr;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entries below the lowest depth reached were never written
  assign stack_top = ({1'b0, pos_r} < min_depth_r) ? (IDX_W'(SLOTS - 1) - pos_r) : stk_q;
  assign rec_valid = ({1'b0, req_r.slot_index} < (DEPTH_W'(SLOTS) - min_depth_r));

  ght_update u_update (
    .req       (req_r),
    .rec       (rec_q),
    .rec_valid (rec_valid),
    .stack_top (stack_top),
    .ctr       (ctr_r),
    .ctr_nxt   (ctr_nxt),
    .res       (res),
    .rec_wr    (rec_wr),
    .stk_wr    (stk_wr)
  );

  always_comb begin
    state_nxt = state_r;
    commit = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r.free_depth <= DEPTH_W'(SLOTS);
      ctr_r.gen <= GEN_W'(1);
      ctr_r.live <= '0;
      ctr_r.bytes <= '0;
      ctr_r.peak <= '0;
      min_depth_r <= DEPTH_W'(SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        ctr_r <= ctr_nxt;
        out_valid_r <= 1'b1;
        if (ctr_nxt.free_depth < min_depth_r) begin
          min_depth_r <= ctr_nxt.free_depth;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
      pos_r <= ctr_r.free_depth[IDX_W-1:0] - IDX_W'(1);
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_q <= rec_mem[in_data.slot_index];
    end
    if (commit && rec_wr.we) begin
      rec_mem[rec_wr.addr] <= rec_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stk_q <= stk_mem[ctr_r.free_depth[IDX_W-1:0] - IDX_W'(1)];
    end
    if (commit && stk_wr.we) begin
      stk_mem[stk_wr.addr] <= stk_wr.data;
    end
  end

endmodule
`default_nettype wire

### tb/sv/generational_handle_table_tb.sv
// Self-checking testbench for generational_handle_table: directed and random beats,
// a scoreboard fed by a predictor of the slot table. Depends on ght_pkg and the RTL.
`timescale 1ns / 1ps
module generational_handle_table_tb;
  import ght_pkg::*;

  localparam int  RANDOM_OPS   = 200;
  localparam int  SETTLE_CYC   = 20;
  localparam longint CYCLE_CAP = 5_000_000;

  typedef struct {
    ght_in_t beat;
    int      gap;
  } queued_beat_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  ght_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ght_out_t out_data;

  generational_handle_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted table state
  logic [IDX_W-1:0]   free_idx  [SLOTS];
  logic [DEPTH_W-1:0] free_cnt;
  logic [GEN_W-1:0]   gen_of    [SLOTS];
  logic               live_of   [SLOTS];
  logic [REFS_W-1:0]  refs_of   [SLOTS];
  logic [SIZE_W-1:0]  size_of   [SLOTS];
  logic [GEN_W-1:0]   next_gen;
  logic [DEPTH_W-1:0] live_cnt;
  logic [BYTES_W-1:0] bytes_now;
  logic [BYTES_W-1:0] bytes_max;

  ght_out_t     replies_due[$];
  queued_beat_t beat_queue[$];
  int           beats_queued = 0;
  int           beats_taken  = 0;
  int           mismatches   = 0;
  bit           calm_in      = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      free_idx[i] = IDX_W'(SLOTS - 1 - i);
      gen_of[i]   = '0;
      live_of[i]  = 1'b0;
      refs_of[i]  = '0;
      size_of[i]  = '0;
    end
    free_cnt  = DEPTH_W'(SLOTS);
    next_gen  = GEN_W'(1);
    live_cnt  = '0;
    bytes_now = '0;
    bytes_max = '0;
  end

  function automatic void drop_slot(logic [IDX_W-1:0] idx);
    live_of[idx] = 1'b0;
    refs_of[idx] = '0;
    if (free_cnt < SLOTS) begin
      free_idx[free_cnt] = idx;
      free_cnt++;
    end
    if (live_cnt > 0) live_cnt--;
    bytes_now = bytes_now - BYTES_W'(size_of[idx]);
  endfunction

  function automatic void handle_table_step(ght_in_t b);
    ght_out_t         r;
    logic [IDX_W-1:0] idx;
    r = '0;
    r.status = ST_OK;
    idx = b.slot_index;
    if (b.op == OP_ALLOC) begin
      if (b.byte_size == '0) begin
        r.status = ST_ZERO;
      end else if (free_cnt == '0) begin
        r.status = ST_FULL;
      end else begin
        free_cnt--;
        idx = free_idx[free_cnt];
        gen_of[idx] = next_gen;
        next_gen = next_gen + 1'b1;
        if (next_gen == '0) next_gen = GEN_W'(1);
        live_of[idx] = 1'b1;
        refs_of[idx] = REFS_W'(1);
        size_of[idx] = b.byte_size;
        live_cnt++;
        bytes_now = bytes_now + BYTES_W'(b.byte_size);
        if (bytes_now > bytes_max) bytes_max = bytes_now;
        r.out_index      = idx;
        r.out_generation = gen_of[idx];
        r.refs_after     = REFS_W'(1);
      end
    end else if (b.op <= OP_UNTRACK) begin
      r.out_index      = idx;
      r.out_generation = gen_of[idx];
      if (!live_of[idx] || b.handle_generation == '0 || gen_of[idx] != b.handle_generation) begin
        r.status = ST_BAD;
      end else begin
        case (b.op)
          OP_LOOKUP: r.refs_after = refs_of[idx];
          OP_RETAIN: begin
            if (refs_of[idx] < REFS_MAX) refs_of[idx]++;
            r.refs_after = refs_of[idx];
          end
          OP_RELEASE: begin
            if (refs_of[idx] > 0) refs_of[idx]--;
            if (refs_of[idx] == '0) begin
              drop_slot(idx);
              r.released = 1'b1;
            end
            r.refs_after = refs_of[idx];
          end
          default: begin
            drop_slot(idx);
            r.released = 1'b1;
          end
        endcase
      end
    end else begin
      r.status    = ST_BAD;
      r.out_index = idx;
    end
    r.live_objects = live_cnt;
    r.total_bytes  = bytes_now;
    r.peak_bytes   = bytes_max;
    replies_due.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_reply(ght_out_t got);
    ght_out_t want;
    if (replies_due.size() == 0) begin
      $error("unexpected result beat: %p", got);
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    check_field("status", want.status, got.status);
    check_field("out_index", want.out_index, got.out_index);
    check_field("out_generation", want.out_generation, got.out_generation);
    check_field("refs_after", want.refs_after, got.refs_after);
    check_field("released", want.released, got.released);
    check_field("live_objects", want.live_objects, got.live_objects);
    check_field("total_bytes", want.total_bytes, got.total_bytes);
    check_field("peak_bytes", want.peak_bytes, got.peak_bytes);
  endfunction

  // Driver
  bit drv_busy  = 0;
  bit gap_armed = 0;
  int gap_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      drv_busy  = 0;
      gap_armed = 0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        handle_table_step(in_data);
        beats_taken++;
        drv_busy = 0;
      end
      if (!drv_busy && beat_queue.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = beat_queue[0].gap;
          gap_armed = 1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          in_data <= beat_queue[0].beat;
          void'(beat_queue.pop_front());
          drv_busy  = 1;
          gap_armed = 0;
        end
      end
      in_valid <= drv_busy;
    end
  end

  // Monitor
  bit calm_out    = 0;
  bit stall_armed = 0;
  bit sink_rdy    = 0;
  int stall_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_armed = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_reply(out_data);
        stall_armed = 0;
      end
      if (!stall_armed) begin
        if ($urandom_range(0, 99) == 0) calm_out = !calm_out;
        stall_left  = calm_out ? 0 : $urandom_range(0, 9);
        stall_armed = 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        sink_rdy = 0;
      end else begin
        sink_rdy = 1;
      end
      out_ready <= sink_rdy;
    end
  end

  longint cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_beat(logic [OP_W-1:0] op, logic [SIZE_W-1:0] sz,
                           logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
    queued_beat_t qb;
    while (beat_queue.size() >= 4) @(negedge clk);
    if ($urandom_range(0, 99) == 0) calm_in = !calm_in;
    qb.beat.op                = op;
    qb.beat.byte_size         = sz;
    qb.beat.slot_index        = idx;
    qb.beat.handle_generation = g;
    qb.gap = calm_in ? 0 : $urandom_range(0, 9);
    beat_queue.push_back(qb);
    beats_queued++;
  endtask

  task automatic wait_taken();
    wait (beats_taken == beats_queued);
    @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_live_slot();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (live_of[(start + k) % SLOTS]) return IDX_W'((start + k) % SLOTS);
    end
    return IDX_W'(start);
  endfunction

  function automatic logic [SIZE_W-1:0] draw_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, 4096));
    endcase
  endfunction

  initial begin
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  g;
    logic [OP_W-1:0]   op;
    int                pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero size, stale handles, refcount walk, unknown ops
    push_beat(OP_ALLOC, '0, '0, '0);
    push_beat(OP_LOOKUP, '0, '0, GEN_W'(1));
    push_beat(OP_ALLOC, '1, '0, '0);
    push_beat(OP_ALLOC, SIZE_W'(1), '1, '1);
    push_beat(OP_LOOKUP, '0, '0, GEN_W'(1));
    push_beat(OP_LOOKUP, '0, '0, '0);
    push_beat(OP_LOOKUP, '0, '0, '1);
    push_beat(OP_RETAIN, '0, IDX_W'(1), GEN_W'(2));
    push_beat(OP_RELEASE, '0, IDX_W'(1), GEN_W'(2));
    push_beat(OP_RELEASE, '0, IDX_W'(1), GEN_W'(2));
    push_beat(OP_RELEASE, '0, IDX_W'(1), GEN_W'(2));
    push_beat(OP_UNTRACK, '0, '0, GEN_W'(1));
    push_beat(OP_ALLOC, SIZE_W'(32'h8000_0000), '0, '0);
    for (int u = OP_UNTRACK + 1; u < 2 ** OP_W; u++)
      push_beat(OP_W'(u), '1, '1, '1);
    push_beat(OP_LOOKUP, '0, '1, '1);
    push_beat(OP_RETAIN, '0, '0, GEN_W'(3));

    // fill to the last slot, then overflow
    for (int i = 1; i < SLOTS; i++)
      push_beat(OP_ALLOC, (i % 4 == 0) ? '1 : draw_size() | SIZE_W'(1), '0, '0);
    push_beat(OP_ALLOC, SIZE_W'(5), '0, '0);
    push_beat(OP_ALLOC, '0, '0, '0);
    wait_taken();

    // random traffic, mostly on live handles
    repeat (RANDOM_OPS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 || live_cnt < 4) begin
        push_beat(OP_ALLOC, draw_size(), IDX_W'($urandom), GEN_W'($urandom));
      end else if (pick < 92) begin
        case ($urandom_range(0, 6))
          0, 1:    op = OP_LOOKUP;
          2, 3:    op = OP_RETAIN;
          4, 5:    op = OP_RELEASE;
          default: op = OP_UNTRACK;
        endcase
        idx = pick_live_slot();
        push_beat(op, SIZE_W'($urandom), idx, gen_of[idx]);
      end else begin
        op = OP_W'($urandom_range(OP_LOOKUP, 2 ** OP_W - 1));
        idx = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom) : pick_live_slot();
        case ($urandom_range(0, 2))
          0:       g = '0;
          1:       g = gen_of[idx] + 1'b1;
          default: g = GEN_W'($urandom);
        endcase
        push_beat(op, SIZE_W'($urandom), idx, g);
      end
    end

    wait_taken();
    wait (replies_due.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
